[design/svpc_pkg.sv]
// Shared types, constants and the sector table for the space vector PWM compare block.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package svpc_pkg;

  typedef logic [2:0]  sector_t;
  typedef logic [13:0] top_t;
  typedef logic [14:0] factor_t;

  // Input word: stationary-frame voltage command, signed Q15.
  typedef struct packed {
    logic signed [15:0] volt_alpha;
    logic signed [15:0] volt_beta;
  } in_word_t;

  // Output word: three compare levels and the sector.
  typedef struct packed {
    logic [15:0] compare_u;
    logic [15:0] compare_v;
    logic [15:0] compare_w;
    sector_t     sector_out;
  } out_word_t;

  // Projection stage contents.
  typedef struct packed {
    logic signed [15:0] beta;
    logic signed [15:0] half_alpha;  // alpha * sqrt3/2
    logic signed [15:0] half_beta;   // beta / 2
  } proj_t;

  // Active and zero times with the sector.
  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t0;
    sector_t     sector;
  } times_t;

  localparam logic signed [15:0] HALF_SQRT3_Q15 = 16'sd28378;
  localparam logic [14:0]        SQRT3_Q14      = 15'd28378;
  localparam top_t               TOP_RESET      = 14'd1000;

  localparam sector_t SECTOR_NONE = 3'd0;
  localparam sector_t SECTOR_1    = 3'd1;
  localparam sector_t SECTOR_2    = 3'd2;
  localparam sector_t SECTOR_3    = 3'd3;
  localparam sector_t SECTOR_4    = 3'd4;
  localparam sector_t SECTOR_5    = 3'd5;
  localparam sector_t SECTOR_6    = 3'd6;

  // Maps the 3-bit projection sign code to a sector. Codes with all signs
  // equal have no sector.
  function automatic sector_t sector_of_code(input logic [2:0] code);
    sector_t sec;
    case (code)
      3'd1:    sec = SECTOR_2;
      3'd2:    sec = SECTOR_6;
      3'd3:    sec = SECTOR_1;
      3'd4:    sec = SECTOR_4;
      3'd5:    sec = SECTOR_3;
      3'd6:    sec = SECTOR_5;
      default: sec = SECTOR_NONE;
    endcase
    return sec;
  endfunction

endpackage

`default_nettype wire

[design/svpc_proj.sv]
// First pipeline stage: alpha and beta projections (alpha*sqrt3/2, beta/2).
// Depends on svpc_pkg.
`default_nettype none

module svpc_proj (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             vld_in,
  input  wire logic             adv,
  input  wire svpc_pkg::in_word_t word_in,
  output logic                  vld,
  output svpc_pkg::proj_t       proj
);
  import svpc_pkg::*;

  logic signed [31:0] alpha_prod;
  proj_t              proj_next;

  always_comb begin
    alpha_prod           = word_in.volt_alpha * HALF_SQRT3_Q15;
    proj_next.beta       = word_in.volt_beta;
    // Floor of the Q15 product; the result fits in 16 bits.
    proj_next.half_alpha = alpha_prod[30:15];
    proj_next.half_beta  = word_in.volt_beta >>> 1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (adv) begin
      vld <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      proj <= proj_next;
    end
  end

endmodule

`default_nettype wire

[design/svpc_times.sv]
// Second and third pipeline stages: sector decode with X/Y/Z scaling, then
// active time selection and the zero time. Depends on svpc_pkg.
`default_nettype none

module svpc_times (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            vld_in,
  input  wire logic            adv_xyz,
  input  wire logic            adv_t,
  input  wire svpc_pkg::proj_t proj,
  input  wire svpc_pkg::factor_t factor,
  input  wire svpc_pkg::top_t  top,
  output logic                 vld_xyz,
  output logic                 vld,
  output svpc_pkg::times_t     times
);
  import svpc_pkg::*;

  // Stage registers for X, Y, Z.
  logic [15:0] x;
  logic [15:0] y;
  logic [15:0] z;
  sector_t     sec_xyz;

  logic signed [16:0] sum_y;
  logic signed [16:0] sum_z;
  logic signed [16:0] u2;
  logic signed [16:0] u3;
  logic [2:0]         code;
  logic signed [31:0] x_prod;
  logic signed [32:0] y_prod;
  logic signed [32:0] z_prod;
  logic signed [15:0] factor_s;

  logic [15:0]        t1;
  logic [15:0]        t2;
  logic signed [18:0] diff;
  times_t             times_next;

  always_comb begin
    sum_y    = 17'(proj.half_alpha) + 17'(proj.half_beta);
    sum_z    = 17'(proj.half_beta) - 17'(proj.half_alpha);
    u2       = 17'(proj.half_alpha) - 17'(proj.half_beta);
    u3       = -sum_y;
    code     = {u3 > 17'sd0, u2 > 17'sd0, proj.beta > 16'sd0};
    factor_s = $signed({1'b0, factor});
    x_prod   = factor_s * proj.beta;
    y_prod   = 33'(factor_s) * 33'(sum_y);
    z_prod   = 33'(factor_s) * 33'(sum_z);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_xyz <= 1'b0;
    end else if (adv_xyz) begin
      vld_xyz <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_xyz) begin
      x       <= x_prod[30:15];
      y       <= y_prod[30:15];
      z       <= z_prod[30:15];
      sec_xyz <= sector_of_code(code);
    end
  end

  always_comb begin
    case (sec_xyz)
      SECTOR_1: begin t1 = 16'd0 - z; t2 = x;         end
      SECTOR_2: begin t1 = z;         t2 = y;         end
      SECTOR_3: begin t1 = x;         t2 = 16'd0 - y; end
      SECTOR_4: begin t1 = 16'd0 - x; t2 = z;         end
      SECTOR_5: begin t1 = 16'd0 - y; t2 = 16'd0 - z; end
      default:  begin t1 = y;         t2 = 16'd0 - x; end
    endcase
    diff              = $signed({5'b0, top}) - $signed({3'b0, t1}) - $signed({3'b0, t2});
    times_next.t1     = t1;
    times_next.t2     = t2;
    // Arithmetic shift right by two, kept modulo 2^16.
    times_next.t0     = diff[17:2];
    times_next.sector = sec_xyz;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (adv_t) begin
      vld <= vld_xyz;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_t) begin
      times <= times_next;
    end
  end

endmodule

`default_nettype wire

[design/svpc_levels.sv]
// Last pipeline stage: forms the three compare levels per sector and holds the
// output word. Depends on svpc_pkg.
`default_nettype none

module svpc_levels (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             vld_in,
  input  wire logic             adv,
  input  wire svpc_pkg::times_t times,
  input  wire svpc_pkg::top_t   top,
  output logic                  vld,
  output svpc_pkg::out_word_t   word
);
  import svpc_pkg::*;

  logic [15:0] mid;
  logic [15:0] high;
  logic [15:0] low;
  logic [15:0] top16;
  out_word_t   word_next;

  always_comb begin
    low   = times.t0;
    mid   = times.t2 + times.t0;
    high  = times.t1 + mid;
    top16 = {2'b0, top};
    word_next.sector_out = times.sector;
    case (times.sector)
      SECTOR_1: begin
        word_next.compare_u = high; word_next.compare_v = mid;  word_next.compare_w = low;
      end
      SECTOR_2: begin
        word_next.compare_u = mid;  word_next.compare_v = high; word_next.compare_w = low;
      end
      SECTOR_3: begin
        word_next.compare_u = low;  word_next.compare_v = high; word_next.compare_w = mid;
      end
      SECTOR_4: begin
        word_next.compare_u = low;  word_next.compare_v = mid;  word_next.compare_w = high;
      end
      SECTOR_5: begin
        word_next.compare_u = mid;  word_next.compare_v = low;  word_next.compare_w = high;
      end
      SECTOR_6: begin
        word_next.compare_u = high; word_next.compare_v = low;  word_next.compare_w = mid;
      end
      default: begin
        // No sector (zero vector or degenerate sign code): all levels at top.
        word_next.compare_u  = top16;
        word_next.compare_v  = top16;
        word_next.compare_w  = top16;
        word_next.sector_out = SECTOR_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (adv) begin
      vld <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      word <= word_next;
    end
  end

endmodule

`default_nettype wire

[design/space_vector_pwm_compare_top.sv]
// Top level of the space vector PWM compare block: configuration register and
// the four-stage pipeline. Depends on svpc_pkg, svpc_proj, svpc_times, svpc_levels.
//
// Usage:
//   The input channel (in_valid, in_ready, in_word) takes one word holding a
//   signed Q15 voltage command (volt_alpha, volt_beta). The output channel
//   (out_valid, out_ready, out_word) returns one word per input word with the
//   three phase compare levels and the sector, in order.
//   The PWM counter top is written through cfg_wr_en and cfg_wr_data; the
//   write takes effect at once and should be made while no word is in flight.
//   An accepted word passes through four register stages on its way to out_valid:
//   projections, sector decode with X/Y/Z scaling, active and zero times, and
//   level ordering into the output register. While out_ready stays high, one
//   word enters per cycle, so the sustained throughput is one word per clock.
//   Each stage carries its own valid bit and loads whenever it is empty or the
//   stage after it moves, so bubbles collapse and a word can be taken while a
//   finished result still waits at the output. When the receiver holds
//   out_ready low the pipeline fills up to four words and then drops in_ready;
//   nothing is lost or repeated.
//   Synchronous reset (rst) empties the pipeline and loads a counter top of
//   1000. The scaling factor top*sqrt3 is registered from the counter top every
//   cycle and follows a write in the next cycle.
`default_nettype none

module space_vector_pwm_compare_top (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire svpc_pkg::in_word_t  in_word,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output svpc_pkg::out_word_t      out_word,
  input  wire logic                cfg_wr_en,
  input  wire svpc_pkg::top_t      cfg_wr_data
);
  import svpc_pkg::*;

  top_t        pwm_period_top;
  factor_t     factor;
  logic [28:0] factor_prod;

  logic   vld_proj;
  logic   vld_xyz;
  logic   vld_times;
  logic   rdy_proj;
  logic   rdy_xyz;
  logic   rdy_times;
  logic   rdy_out;
  proj_t  proj;
  times_t times;

  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_period_top <= TOP_RESET;
    end else if (cfg_wr_en) begin
      pwm_period_top <= cfg_wr_data;
    end
  end

  // factor = floor(top * sqrt3 in Q14); fits in 15 bits.
  assign factor_prod = 29'(pwm_period_top) * 29'(SQRT3_Q14);

  always_ff @(posedge clk) begin
    factor <= factor_prod[28:14];
  end

  // A stage may load when it is empty or its successor is moving.
  assign rdy_out   = !out_valid || out_ready;
  assign rdy_times = !vld_times || rdy_out;
  assign rdy_xyz   = !vld_xyz   || rdy_times;
  assign rdy_proj  = !vld_proj  || rdy_xyz;
  assign in_ready  = rdy_proj;

  svpc_proj u_proj (
    .clk     (clk),
    .rst     (rst),
    .vld_in  (in_valid),
    .adv     (rdy_proj),
    .word_in (in_word),
    .vld     (vld_proj),
    .proj    (proj)
  );

  svpc_times u_times (
    .clk     (clk),
    .rst     (rst),
    .vld_in  (vld_proj),
    .adv_xyz (rdy_xyz),
    .adv_t   (rdy_times),
    .proj    (proj),
    .factor  (factor),
    .top     (pwm_period_top),
    .vld_xyz (vld_xyz),
    .vld     (vld_times),
    .times   (times)
  );

  svpc_levels u_levels (
    .clk    (clk),
    .rst    (rst),
    .vld_in (vld_times),
    .adv    (rdy_out),
    .times  (times),
    .top    (pwm_period_top),
    .vld    (out_valid),
    .word   (out_word)
  );

endmodule

`default_nettype wire

[test/svpc_level_checker.sv]
// Scoreboard for the space vector PWM compare block: predicts the compare levels of every
// accepted input word and checks the output words against them, in order.
// Depends on svpc_pkg for the word types, the counter top type and the sector names.

module svpc_level_checker (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire logic                in_ready,
  input  wire svpc_pkg::in_word_t  in_word,
  input  wire logic                out_valid,
  input  wire logic                out_ready,
  input  wire svpc_pkg::out_word_t out_word,
  input  wire logic                cfg_wr_en,
  input  wire svpc_pkg::top_t      cfg_wr_data,
  output int                       mismatches,
  output int                       outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import svpc_pkg::*;

  localparam longint ONE_HALF_Q15   = 16384;
  localparam longint SQRT3_HALF_Q15 = 28378;
  localparam longint SQRT3_Q14_K    = 28378;
  localparam top_t   TOP_AFTER_RST  = 14'd1000;

  // Sign code {u3 > 0, u2 > 0, beta > 0} to sector; all-equal signs have no sector.
  sector_t sector_by_code [8] = '{SECTOR_NONE, SECTOR_2, SECTOR_6, SECTOR_1,
                                  SECTOR_4, SECTOR_3, SECTOR_5, SECTOR_NONE};

  top_t      period_top = TOP_AFTER_RST;
  out_word_t expected_levels_q [$];

  function automatic out_word_t predict_levels(input in_word_t w, input top_t top);
    longint     a, b, tp, hb, ha, u2, u3, factor;
    logic [2:0] code;
    sector_t    sec;
    logic [15:0] x, y, z, t1, t2, t0, mid, peak;
    out_word_t  r;
    a  = longint'($signed(w.volt_alpha));
    b  = longint'($signed(w.volt_beta));
    tp = longint'(top);
    // Arithmetic shifts on signed values floor, which is the Q15/Q14 rounding here.
    hb = (b * ONE_HALF_Q15) >>> 15;
    ha = (a * SQRT3_HALF_Q15) >>> 15;
    u2 = ha - hb;
    u3 = -hb - ha;
    code = {u3 > 0, u2 > 0, b > 0};
    sec  = sector_by_code[code];
    if ((a == 0 && b == 0) || sec == SECTOR_NONE) begin
      r.compare_u  = 16'(top);
      r.compare_v  = 16'(top);
      r.compare_w  = 16'(top);
      r.sector_out = SECTOR_NONE;
      return r;
    end
    factor = (tp * SQRT3_Q14_K) >>> 14;
    x = 16'((factor * b) >>> 15);
    y = 16'((factor * (ha + hb)) >>> 15);
    z = 16'((factor * (hb - ha)) >>> 15);
    case (sec)
      SECTOR_1: begin t1 = -z; t2 = x;  end
      SECTOR_2: begin t1 = z;  t2 = y;  end
      SECTOR_3: begin t1 = x;  t2 = -y; end
      SECTOR_4: begin t1 = -x; t2 = z;  end
      SECTOR_5: begin t1 = -y; t2 = -z; end
      default:  begin t1 = y;  t2 = -x; end
    endcase
    t0   = 16'((tp - longint'(t1) - longint'(t2)) >>> 2);
    mid  = t2 + t0;
    peak = t1 + t2 + t0;
    case (sec)
      SECTOR_1: begin r.compare_u = peak; r.compare_v = mid;  r.compare_w = t0;   end
      SECTOR_2: begin r.compare_u = mid;  r.compare_v = peak; r.compare_w = t0;   end
      SECTOR_3: begin r.compare_u = t0;   r.compare_v = peak; r.compare_w = mid;  end
      SECTOR_4: begin r.compare_u = t0;   r.compare_v = mid;  r.compare_w = peak; end
      SECTOR_5: begin r.compare_u = mid;  r.compare_v = t0;   r.compare_w = peak; end
      default:  begin r.compare_u = peak; r.compare_v = t0;   r.compare_w = mid;  end
    endcase
    r.sector_out = sec;
    return r;
  endfunction

  task automatic check_field(input string field, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t svpc %s mismatch: expected %0d actual %0d", $time, field, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    out_word_t exp_w;
    if (rst) begin
      period_top = TOP_AFTER_RST;
      expected_levels_q.delete();
    end else begin
      if (cfg_wr_en)
        period_top = cfg_wr_data;
      if (out_valid && out_ready) begin
        if (expected_levels_q.size() == 0) begin
          $display("%0t svpc output word with none expected: actual %h", $time, out_word);
          mismatches++;
        end else begin
          exp_w = expected_levels_q.pop_front();
          check_field("compare_u", exp_w.compare_u, out_word.compare_u);
          check_field("compare_v", exp_w.compare_v, out_word.compare_v);
          check_field("compare_w", exp_w.compare_w, out_word.compare_w);
          check_field("sector_out", 16'(exp_w.sector_out), 16'(out_word.sector_out));
        end
      end
      if (in_valid && in_ready)
        expected_levels_q.push_back(predict_levels(in_word, period_top));
    end
    outstanding = expected_levels_q.size();
  end

endmodule

[test/tb_space_vector_pwm_compare_top.sv]
// Testbench top for space_vector_pwm_compare_top: clock, reset, stimulus and verdict.
// Depends on svpc_pkg, the block itself and svpc_level_checker, which does all checking.

module tb_space_vector_pwm_compare_top;
  timeunit 1ns;
  timeprecision 1ps;
  import svpc_pkg::*;

  // Run limit, with ample margin over the length of a correct run.
  localparam int LIMIT_CYCLES   = 800000;
  localparam int SETTLE_CYCLES  = 8;   // quiet time after the expected words are back
  localparam int WORDS_PER_STEP = 250;

  // Receiver behaviors; each runs for a random stretch of cycles.
  localparam int RX_FREE    = 0;  // always ready
  localparam int RX_COIN    = 1;  // ready half of the time
  localparam int RX_CHOKED  = 2;  // ready one cycle in eight
  localparam int RX_HICCUP  = 3;  // an occasional single stall

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_word;
  logic      cfg_wr_en = 1'b0;
  top_t      cfg_wr_data = '0;

  int mismatches;
  int outstanding;
  int cycle_count = 0;
  int rx_mode = RX_FREE;
  int rx_stretch = 0;

  // The counter tops used for the random part, extremes first.
  top_t step_tops [6] = '{14'd16383, 14'd1, 14'd2, 14'd8191, 14'd0, 14'd1000};

  // Values that sit on the rails of a Q15 field or right around zero.
  logic signed [15:0] rails [5] = '{-16'sd32768, 16'sd32767, 16'sd0, 16'sd1, -16'sd1};

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  space_vector_pwm_compare_top DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_word    (in_word),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_word   (out_word),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  svpc_level_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_word    (in_word),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_word   (out_word),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  // Hard stop: if the run hangs, whatever the cause, it ends here as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  // The receiver switches between behaviors of its own, independent of the sender,
  // so that stalls land on every phase of the pipeline's work, including the times
  // when it is full and in_ready must drop.
  always @(negedge clk) begin
    if (rx_stretch == 0) begin
      rx_stretch = $urandom_range(20, 200);
      rx_mode    = $urandom_range(RX_FREE, RX_HICCUP);
    end
    rx_stretch--;
    case (rx_mode)
      RX_FREE:   out_ready <= 1'b1;
      RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
      RX_CHOKED: out_ready <= ($urandom_range(0, 7) == 0);
      default:   out_ready <= ($urandom_range(0, 15) != 0);
    endcase
  end

  // Presents one word at the falling edge and holds it until the rising edge that
  // accepts it. Valid is left high, so a word sent right after this one follows
  // without a bubble; idle_for is what lowers it.
  task automatic send_word(input in_word_t w);
    @(negedge clk);
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_pair(input logic signed [15:0] alpha, input logic signed [15:0] beta);
    in_word_t w;
    w.volt_alpha = alpha;
    w.volt_beta  = beta;
    send_word(w);
  endtask

  // While valid is low the payload is junk on purpose; the block must ignore it.
  task automatic idle_for(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_valid <= 1'b0;
      in_word  <= in_word_t'($urandom);
    end
  endtask

  // Stops sending, lets every expected word come back and the pipeline settle, and
  // only then writes a new counter top. The factor behind X, Y and Z is registered
  // from the counter top and follows the write before the next word can reach that stage.
  task automatic write_top(input top_t value);
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Corner vectors: the zero vector, tiny vectors right around zero (some with no
  // sector, handled like the zero vector), the rails of both fields, one vector
  // inside each of the six sectors and one on a sector edge.
  task automatic send_corners();
    send_pair(16'sd0, 16'sd0);
    send_pair(16'sd1, 16'sd0);
    send_pair(-16'sd1, 16'sd0);
    send_pair(16'sd0, 16'sd1);
    send_pair(16'sd0, -16'sd1);
    send_pair(-16'sd1, -16'sd1);
    send_pair(16'sd32767, 16'sd0);
    send_pair(-16'sd32768, 16'sd0);
    send_pair(16'sd0, 16'sd32767);
    send_pair(16'sd0, -16'sd32768);
    send_pair(16'sd32767, 16'sd32767);
    send_pair(-16'sd32768, -16'sd32768);
    send_pair(16'sd32767, -16'sd32768);
    send_pair(-16'sd32768, 16'sd32767);
    send_pair(16'sd13856, 16'sd8000);
    send_pair(16'sd0, 16'sd16000);
    send_pair(-16'sd13856, 16'sd8000);
    send_pair(-16'sd13856, -16'sd8000);
    send_pair(16'sd0, -16'sd16000);
    send_pair(16'sd13856, -16'sd8000);
    send_pair(16'sd8000, 16'sd13856);
  endtask

  // Mostly full-range words, with a share of tiny, single-axis, rail and
  // mid-range vectors so that rounding near zero and wrap-around both get hit.
  function automatic in_word_t random_word();
    in_word_t w;
    int pick;
    w    = in_word_t'($urandom);
    pick = $urandom_range(0, 9);
    if (pick == 6) begin
      w.volt_alpha = 16'($urandom_range(0, 8) - 4);
      w.volt_beta  = 16'($urandom_range(0, 8) - 4);
    end else if (pick == 7) begin
      if ($urandom_range(0, 1) == 0)
        w.volt_alpha = '0;
      else
        w.volt_beta = '0;
    end else if (pick == 8) begin
      w.volt_alpha = rails[$urandom_range(0, 4)];
      w.volt_beta  = rails[$urandom_range(0, 4)];
    end else if (pick == 9) begin
      w.volt_alpha = 16'($urandom_range(0, 4000) - 2000);
      w.volt_beta  = 16'($urandom_range(0, 4000) - 2000);
    end
    return w;
  endfunction

  // Bursts of random length separated by random gaps; about a quarter of the
  // bursts run straight into the next one with no gap at all.
  task automatic send_random(input int count);
    int sent;
    int burst;
    int gap;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 48);
      gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      for (int i = 0; i < burst && sent < count; i++) begin
        send_word(random_word());
        sent++;
      end
      if (gap > 0)
        idle_for(gap);
    end
  endtask

  initial begin
    // Synchronous reset, released at a falling edge.
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // The corners first under the counter top that reset leaves behind.
    send_corners();

    // Then one step per counter top: the extremes 16383 and 1, a few others and
    // one random value. Each write waits until the block has gone idle, so every
    // step also forces the sender to pause until all results are back.
    for (int s = 0; s < 6; s++) begin
      if (s == 4)
        step_tops[s] = top_t'($urandom_range(3, 16382));
      write_top(step_tops[s]);
      send_corners();
      send_random(WORDS_PER_STEP);
    end

    // Drain: every expected word must come back, then a few quiet cycles so that
    // any stray extra word would still be caught by the checker.
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

[space_vector_pwm_compare_top.f]
design/svpc_pkg.sv
design/svpc_proj.sv
design/svpc_times.sv
design/svpc_levels.sv
design/space_vector_pwm_compare_top.sv
test/svpc_level_checker.sv
test/tb_space_vector_pwm_compare_top.sv
